FILE: design/tmfv_pkg.sv
// Shared constants and types for the tracker module file validator.
package tmfv_pkg;

	// Largest channel count a new-format header may declare
	localparam int CHANNEL_LIMIT = 16;
	// Width of the file byte counter
	localparam int LENGTH_BITS = 24;

	// Skip lengths reach positions * channels * 2 plus the subsong table
	localparam int SECT_W = $clog2(1000 * CHANNEL_LIMIT * 2 + 512);
	localparam int SKIP_W = 21;

	localparam logic [7:0] MAGIC_H = 8'h48;
	localparam logic [7:0] MAGIC_V = 8'h56;
	localparam logic [7:0] MAGIC_L = 8'h4C;
	localparam logic [7:0] MAGIC_T = 8'h54;
	localparam logic [7:0] MAGIC_X = 8'h58;

	localparam logic [7:0] NEW_VER_LIMIT  = 8'd2;   // new format: version below this
	localparam logic [7:0] OLD_VER_MAX    = 8'd2;   // old format: version up to this
	localparam logic [11:0] POS_MAX       = 12'd1000;
	localparam logic [7:0] STEPS_MAX      = 8'd64;
	localparam logic [7:0] INSTR_MAX      = 8'd64;
	localparam logic [7:0] SUBSONG_FX_MAX = 8'd4;
	localparam logic [7:0] STEP_EMPTY     = 8'd63;
	localparam logic [2:0] MODE_MAX       = 3'd5;
	localparam logic [6:0] NUL_SAT        = 7'd127;
	localparam logic [6:0] BASE_CHANNELS  = 7'd4;
	localparam logic [4:0] INS_HEAD_LAST  = 5'd21;
	localparam logic [4:0] INS_MODE_IDX   = 5'd1;

	typedef logic [LENGTH_BITS-1:0] off_t;
	typedef logic [SECT_W-1:0] sect_t;

	// Walk phase, one-hot
	typedef enum logic [6:0] {
		PH_HEAD    = 7'b0000001,
		PH_SKIP    = 7'b0000010,
		PH_STEP    = 7'b0000100,
		PH_TAIL    = 7'b0001000,
		PH_INSHDR  = 7'b0010000,
		PH_INSTAIL = 7'b0100000,
		PH_DONE    = 7'b1000000
	} phase_t;

endpackage

FILE: design/tracker_module_file_validator.sv
// Streaming structural validator for tracker module files, one byte per cycle.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata[7:0] = data_byte, s_tlast = final_byte
//  m_*     | out | m_tvalid/m_tready | m_tdata[0] = file_ok, m_tdata[7:1] = 0
//
// One byte is taken every cycle unless stalled; the input register feeds one pass of
// walk logic whose result lands in the state registers or, on a last byte, in the verdict
// register. The verdict passes through the input register and then the verdict register.
// Only a last byte meeting a full, unread verdict register stalls the input side.
// arst_n clears all control state; after each verdict the walk returns to the header phase.
module tracker_module_file_validator
	import tmfv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // final_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] file_ok, [7:1] zero
);

	localparam logic [6:0] CH_LIMIT = 7'(CHANNEL_LIMIT);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// walk state
	logic [7:0]  hdr_q [16];
	off_t        off_q;
	phase_t      phase_q;
	sect_t       sbl_q;
	logic [8:0]  track_q;
	logic [6:0]  step_q;
	logic [6:0]  instr_q;
	logic [15:0] name_start_q;
	logic [6:0]  nul_q;
	logic        prior_nul_q;
	logic        new_fmt_q;
	logic        failed_q;
	logic [SKIP_W-1:0] skip_q;

	// verdict register
	logic out_valid_q;
	logic file_ok_q;

	logic advance;

	// next-state values
	off_t        off_n;
	phase_t      phase_n;
	sect_t       sbl_n;
	logic [8:0]  track_n;
	logic [6:0]  step_n;
	logic [6:0]  instr_n;
	logic [15:0] name_start_n;
	logic [6:0]  nul_n;
	logic        prior_nul_n;
	logic        new_fmt_n;
	logic        failed_n;
	logic        verdict;

	// header decode
	logic        is_hvl;
	logic        is_thx;
	logic [11:0] positions;
	logic [6:0]  channels;
	logic [18:0] pos_x_ch;
	logic [SKIP_W-1:0] skip_calc;
	logic        hdr_bad;

	// step helpers
	logic        do_tracks;
	logic        do_step_done;
	logic        do_ins_done;
	logic        do_ins_begin;
	logic [2:0]  zero_cnt;
	logic        ns_small;
	logic [7:0]  b_at;
	logic [10:0] tail_len;
	logic [8:0]  track_inc;
	logic [6:0]  step_inc;
	logic [6:0]  instr_inc;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, file_ok_q};

	// decode header fields from the stored bytes
	always_comb begin
		is_hvl    = hdr_q[0] == MAGIC_H && hdr_q[1] == MAGIC_V && hdr_q[2] == MAGIC_L &&
			hdr_q[3] < NEW_VER_LIMIT;
		is_thx    = hdr_q[0] == MAGIC_T && hdr_q[1] == MAGIC_H && hdr_q[2] == MAGIC_X &&
			hdr_q[3] <= OLD_VER_MAX;
		positions = {hdr_q[6][3:0], hdr_q[7]};
		channels  = is_hvl ? (7'(hdr_q[8][7:2]) + BASE_CHANNELS) : BASE_CHANNELS;
		pos_x_ch  = 19'(positions) * 19'(channels);
		skip_calc = SKIP_W'({pos_x_ch, 1'b0}) + SKIP_W'({hdr_q[13], 1'b0}) -
			(is_hvl ? SKIP_W'(0) : SKIP_W'(2));
		hdr_bad   = (!is_hvl && !is_thx) || positions == 12'd0 || positions > POS_MAX ||
			channels > CH_LIMIT || hdr_q[10] == 8'd0 || hdr_q[10] > STEPS_MAX ||
			hdr_q[12] > INSTR_MAX || (is_hvl && byte_s1 > SUBSONG_FX_MAX);
	end

	// count NULs among the header bytes already inside the name area
	always_comb begin
		zero_cnt = 3'd0;
		ns_small = hdr_q[4] == 8'd0 && byte_s1 <= 8'd5;
		for (int k = 0; k < 6; k++) begin
			b_at = (k == 5) ? byte_s1 : hdr_q[k];
			if (ns_small && 3'(k) >= byte_s1[2:0] && b_at == 8'd0) begin
				zero_cnt = zero_cnt + 3'd1;
			end
		end
	end

	// walk one byte
	always_comb begin
		off_n        = off_q;
		phase_n      = phase_q;
		sbl_n        = sbl_q;
		track_n      = track_q;
		step_n       = step_q;
		instr_n      = instr_q;
		name_start_n = name_start_q;
		nul_n        = nul_q;
		prior_nul_n  = prior_nul_q;
		new_fmt_n    = new_fmt_q;
		failed_n     = failed_q;
		do_tracks    = 1'b0;
		do_step_done = 1'b0;
		do_ins_done  = 1'b0;
		do_ins_begin = 1'b0;
		tail_len     = new_fmt_q ? (11'(byte_s1) * 11'd5) : (11'(byte_s1) * 11'd4);
		track_inc    = track_q + 9'd1;
		step_inc     = step_q + 7'd1;
		instr_inc    = instr_q + 7'd1;

		if (&off_q) begin
			failed_n = 1'b1;
		end else begin
			off_n = off_q + off_t'(1);
			// name area NUL tracking
			if (off_q == off_t'(5)) begin
				name_start_n = {hdr_q[4], byte_s1};
				nul_n        = nul_q + 7'(zero_cnt);
				prior_nul_n  = ns_small && byte_s1 == 8'd0;
			end else if (off_q > off_t'(5)) begin
				prior_nul_n = (32'(off_q) >= 32'(name_start_q)) && byte_s1 == 8'd0;
				if (prior_nul_n && nul_q < NUL_SAT) begin
					nul_n = nul_q + 7'd1;
				end
			end
			// structure walk
			if (off_q == off_t'(15)) begin
				if (hdr_bad) begin
					failed_n = 1'b1;
					phase_n  = PH_DONE;
				end else begin
					new_fmt_n = is_hvl;
					sbl_n     = skip_q[SECT_W-1:0];
					if (skip_q == '0) begin
						do_tracks = 1'b1;
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end else if (off_q > off_t'(15) && !failed_q) begin
				unique case (phase_q)
					PH_SKIP, PH_TAIL, PH_INSTAIL: begin
						sbl_n = sbl_q - sect_t'(1);
						if (sbl_q == sect_t'(1)) begin
							do_tracks    = phase_q == PH_SKIP;
							do_step_done = phase_q == PH_TAIL;
							do_ins_done  = phase_q == PH_INSTAIL;
						end
					end
					PH_STEP: begin
						if (new_fmt_q && byte_s1 == STEP_EMPTY) begin
							do_step_done = 1'b1;
						end else begin
							sbl_n   = new_fmt_q ? sect_t'(4) : sect_t'(2);
							phase_n = PH_TAIL;
						end
					end
					PH_INSHDR: begin
						if (sbl_q == sect_t'(INS_MODE_IDX) && byte_s1[2:0] > MODE_MAX) begin
							failed_n = 1'b1;
							phase_n  = PH_DONE;
						end else if (sbl_q == sect_t'(INS_HEAD_LAST)) begin
							sbl_n = sect_t'(tail_len);
							if (tail_len == 11'd0) begin
								do_ins_done = 1'b1;
							end else begin
								phase_n = PH_INSTAIL;
							end
						end else begin
							sbl_n = sbl_q + sect_t'(1);
						end
					end
					PH_HEAD, PH_DONE: begin
					end
					default: begin
					end
				endcase
			end
		end

		// enter the track area
		if (do_tracks) begin
			track_n = {8'd0, hdr_q[6][7]};
			step_n  = 7'd0;
			if ({8'd0, hdr_q[6][7]} > {1'b0, hdr_q[11]}) begin
				do_ins_begin = 1'b1;
			end else begin
				phase_n = PH_STEP;
			end
		end
		// close a step, advance track
		if (do_step_done) begin
			phase_n = PH_STEP;
			step_n  = step_inc;
			if ({1'b0, step_inc} >= hdr_q[10]) begin
				step_n  = 7'd0;
				track_n = track_inc;
				if (track_inc > {1'b0, hdr_q[11]}) begin
					do_ins_begin = 1'b1;
				end
			end
		end
		// close an instrument
		if (do_ins_done) begin
			instr_n = instr_inc;
			if ({1'b0, instr_inc} >= hdr_q[12]) begin
				phase_n = PH_DONE;
			end else begin
				sbl_n   = '0;
				phase_n = PH_INSHDR;
			end
		end
		// enter the instrument area
		if (do_ins_begin) begin
			if (hdr_q[12] == 8'd0) begin
				phase_n = PH_DONE;
			end else begin
				instr_n = 7'd0;
				sbl_n   = '0;
				phase_n = PH_INSHDR;
			end
		end

		verdict = !failed_n && off_n >= off_t'(16) && phase_n == PH_DONE &&
			({1'b0, nul_n} >= (hdr_q[12] + 8'd1) || (nul_n != 7'd0 && prior_nul_n));
	end

	// take a request into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// hold header bytes and the precomputed skip length
	always_ff @(posedge clk) begin
		if (advance && !(&off_q)) begin
			if (off_q < off_t'(16)) begin
				hdr_q[off_q[3:0]] <= byte_s1;
			end
			if (off_q == off_t'(14)) begin
				skip_q <= skip_calc;
			end
		end
	end

	// advance walk state; clear it after each verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q        <= '0;
			phase_q      <= PH_HEAD;
			sbl_q        <= '0;
			track_q      <= '0;
			step_q       <= '0;
			instr_q      <= '0;
			name_start_q <= '0;
			nul_q        <= '0;
			prior_nul_q  <= 1'b0;
			new_fmt_q    <= 1'b0;
			failed_q     <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				off_q        <= '0;
				phase_q      <= PH_HEAD;
				sbl_q        <= '0;
				track_q      <= '0;
				step_q       <= '0;
				instr_q      <= '0;
				name_start_q <= '0;
				nul_q        <= '0;
				prior_nul_q  <= 1'b0;
				new_fmt_q    <= 1'b0;
				failed_q     <= 1'b0;
			end else begin
				off_q        <= off_n;
				phase_q      <= phase_n;
				sbl_q        <= sbl_n;
				track_q      <= track_n;
				step_q       <= step_n;
				instr_q      <= instr_n;
				name_start_q <= name_start_n;
				nul_q        <= nul_n;
				prior_nul_q  <= prior_nul_n;
				new_fmt_q    <= new_fmt_n;
				failed_q     <= failed_n;
			end
		end
	end

	// load the verdict, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			file_ok_q   <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
			file_ok_q   <= verdict;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a verdict returns the walk to the start of a file
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (phase_q == PH_HEAD && off_q == '0))
		else $error("walk not restarted after verdict");

	// the walk leaves the header phase only after the whole header
	a_hdr_first: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEAD) |-> (off_q >= off_t'(16)))
		else $error("walk left header phase early");

	// counted sections never sit at zero bytes left
	a_sect_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP || phase_q == PH_TAIL || phase_q == PH_INSTAIL) |->
		(sbl_q != '0))
		else $error("empty counted section");

	// step index stays inside the track
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STEP || phase_q == PH_TAIL) |-> ({1'b0, step_q} < hdr_q[10]))
		else $error("step index beyond track length");

endmodule

FILE: tb/sv/tb_tracker_module_file_validator.sv
// Testbench for the tracker module file validator: file builder, byte-level predictor, checker.
module tb_tracker_module_file_validator;
	import tmfv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no transfer on either side before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	localparam off_t OFF_LAST = '1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;   // [7:0] data_byte
	logic       s_tlast = 1'b0;   // final_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [0] file_ok, [7:1] zero

	tracker_module_file_validator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock
	initial begin
		forever #1 clk = ~clk;
	end

	// Idle and stall rates in percent
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Expected verdicts, oldest first
	logic [7:0] verdict_q[$];
	int errors = 0;
	int bytes_seen = 0;
	int files_seen = 0;
	int verdicts_checked = 0;
	int verdicts_valid = 0;
	int quiet_cycles = 0;

	// File under construction and landmarks inside it
	logic [7:0] file_q[$];
	int first_step_at;
	int first_ins_at;

	// Predictor state
	logic [7:0]  hdr_b[16];
	off_t        offs;
	phase_t      ph;
	int unsigned left;
	int unsigned trk;
	int unsigned stp;
	int unsigned ins;
	int unsigned nstart;
	int unsigned nuls;
	bit          prev_nul;
	bit          hvl_f;
	bit          fail_f;

	function automatic void clear_walk();
		for (int k = 0; k < 16; k++)
			hdr_b[k] = 8'd0;
		offs = '0;
		ph = PH_HEAD;
		left = 0;
		trk = 0;
		stp = 0;
		ins = 0;
		nstart = 0;
		nuls = 0;
		prev_nul = 1'b0;
		hvl_f = 1'b0;
		fail_f = 1'b0;
	endfunction

	function automatic void start_instr();
		if (hdr_b[12] == 8'd0) begin
			ph = PH_DONE;
		end else begin
			ins = 0;
			left = 0;
			ph = PH_INSHDR;
		end
	endfunction

	function automatic void start_tracks();
		trk = hdr_b[6][7] ? 1 : 0;
		stp = 0;
		if (trk > hdr_b[11])
			start_instr();
		else
			ph = PH_STEP;
	endfunction

	function automatic void end_step();
		ph = PH_STEP;
		stp++;
		if (stp >= hdr_b[10]) begin
			stp = 0;
			trk++;
			if (trk > hdr_b[11])
				start_instr();
		end
	endfunction

	function automatic void end_instr();
		ins++;
		if (ins >= hdr_b[12]) begin
			ph = PH_DONE;
		end else begin
			left = 0;
			ph = PH_INSHDR;
		end
	endfunction

	// Check the 16 header bytes and set up the table skip
	function automatic void judge_header();
		bit is_new;
		bit is_old;
		int unsigned npos;
		int unsigned nch;
		int unsigned span;
		is_new = hdr_b[0] == MAGIC_H && hdr_b[1] == MAGIC_V && hdr_b[2] == MAGIC_L &&
			hdr_b[3] < NEW_VER_LIMIT;
		is_old = hdr_b[0] == MAGIC_T && hdr_b[1] == MAGIC_H && hdr_b[2] == MAGIC_X &&
			hdr_b[3] <= OLD_VER_MAX;
		npos = {hdr_b[6][3:0], hdr_b[7]};
		nch = is_new ? hdr_b[8][7:2] + 4 : 4;
		if ((!is_new && !is_old) || npos == 0 || npos > POS_MAX || nch > CHANNEL_LIMIT ||
			hdr_b[10] == 8'd0 || hdr_b[10] > STEPS_MAX || hdr_b[12] > INSTR_MAX ||
			(is_new && hdr_b[15] > SUBSONG_FX_MAX)) begin
			fail_f = 1'b1;
			ph = PH_DONE;
			return;
		end
		hvl_f = is_new;
		span = (is_new ? 16 : 14) + hdr_b[13] * 2 + npos * nch * 2;
		left = span - 16;
		if (left == 0)
			start_tracks();
		else
			ph = PH_SKIP;
	endfunction

	// Advance the structure walk by one byte past the header
	function automatic void walk(logic [7:0] v);
		case (ph)
			PH_SKIP: begin
				left--;
				if (left == 0)
					start_tracks();
			end
			PH_STEP: begin
				if (hvl_f && v == STEP_EMPTY) begin
					end_step();
				end else begin
					left = hvl_f ? 4 : 2;
					ph = PH_TAIL;
				end
			end
			PH_TAIL: begin
				left--;
				if (left == 0)
					end_step();
			end
			PH_INSHDR: begin
				if (left == INS_MODE_IDX && v[2:0] > MODE_MAX) begin
					fail_f = 1'b1;
					ph = PH_DONE;
				end else if (left == INS_HEAD_LAST) begin
					left = v * (hvl_f ? 5 : 4);
					if (left == 0)
						end_instr();
					else
						ph = PH_INSTAIL;
				end else begin
					left++;
				end
			end
			PH_INSTAIL: begin
				left--;
				if (left == 0)
					end_instr();
			end
			default: begin
			end
		endcase
	endfunction

	// Predict one accepted byte; queue a verdict on the last byte of a file
	function automatic void scan_byte(logic [7:0] v, logic last);
		bit names_ok;
		bit ok;
		if (offs >= OFF_LAST) begin
			fail_f = 1'b1;
		end else begin
			if (offs < 16)
				hdr_b[offs[3:0]] = v;
			if (offs == 5) begin
				nstart = {hdr_b[4], hdr_b[5]};
				for (int unsigned k = nstart; k <= 5; k++)
					if (hdr_b[k] == 8'd0 && nuls < NUL_SAT)
						nuls++;
				prev_nul = nstart <= 5 && v == 8'd0;
			end else if (offs > 5) begin
				prev_nul = offs >= nstart && v == 8'd0;
				if (prev_nul && nuls < NUL_SAT)
					nuls++;
			end
			if (offs == 15)
				judge_header();
			else if (offs > 15 && !fail_f)
				walk(v);
			offs = offs + 1'b1;
		end
		if (last) begin
			names_ok = nuls >= hdr_b[12] + 1 || (nuls >= 1 && prev_nul);
			ok = !fail_f && offs >= 16 && ph == PH_DONE && names_ok;
			verdict_q.push_back({7'd0, ok});
			clear_walk();
		end
	endfunction

	initial clear_walk();

	// Receiver stalls
	always @(posedge clk) begin
		m_tready <= $urandom_range(99, 0) >= recv_stall_pct;
	end

	// Check verdicts, then feed accepted bytes to the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				verdicts_checked++;
				if (m_tdata == 8'd1)
					verdicts_valid++;
				if (verdict_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("verdict %0h with no file pending", m_tdata);
				end else if (m_tdata !== verdict_q[0]) begin
					errors++;
					if (errors <= 10)
						$display("verdict mismatch: expected file_ok %0h, got %0h",
							verdict_q[0], m_tdata);
					void'(verdict_q.pop_front());
				end else begin
					void'(verdict_q.pop_front());
				end
			end
			if (s_tvalid && s_tready) begin
				bytes_seen++;
				if (s_tlast)
					files_seen++;
				scan_byte(s_tdata, s_tlast);
			end
		end
	end

	// Hang detection
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Present one byte and hold it until it is taken
	task automatic send_byte(input logic [7:0] v, input logic last);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	// Build a well-formed module file from the given header limits, random content elsewhere
	task automatic make_module(input bit is_new, input int npos, input int nch, input int nsteps,
		input bit skip0, input int trk_hi, input int n_ins, input int n_names, input int junk);
		int span;
		int cnt;
		logic [7:0] b;
		file_q.delete();
		file_q.push_back(is_new ? MAGIC_H : MAGIC_T);
		file_q.push_back(is_new ? MAGIC_V : MAGIC_H);
		file_q.push_back(is_new ? MAGIC_L : MAGIC_X);
		file_q.push_back(8'(is_new ? $urandom_range(1, 0) : $urandom_range(2, 0)));
		file_q.push_back(8'd0);
		file_q.push_back(8'd0);
		file_q.push_back({skip0, 3'($urandom_range(7, 0)), 4'(npos >> 8)});
		file_q.push_back(8'(npos));
		file_q.push_back(is_new ? {6'(nch - 4), 2'($urandom_range(3, 0))} :
			8'($urandom_range(255, 0)));
		file_q.push_back(8'($urandom_range(255, 0)));
		file_q.push_back(8'(nsteps));
		file_q.push_back(8'(trk_hi));
		file_q.push_back(8'(n_ins));
		file_q.push_back(8'($urandom_range(3, 0)));
		file_q.push_back(8'($urandom_range(255, 0)));
		file_q.push_back(8'(is_new ? $urandom_range(4, 0) : $urandom_range(255, 0)));
		// subsong and position tables
		span = (is_new ? 16 : 14) + file_q[13] * 2 + npos * (is_new ? nch : 4) * 2 - 16;
		for (int k = 0; k < span; k++)
			file_q.push_back(8'($urandom_range(255, 0)));
		// track steps
		first_step_at = file_q.size();
		for (int t = skip0; t <= trk_hi; t++) begin
			for (int s = 0; s < nsteps; s++) begin
				if (is_new && $urandom_range(1, 0) == 0) begin
					file_q.push_back(STEP_EMPTY);
				end else begin
					b = 8'($urandom_range(255, 0));
					if (is_new && b == STEP_EMPTY)
						b = 8'd0;
					file_q.push_back(b);
					repeat (is_new ? 4 : 2) file_q.push_back(8'($urandom_range(255, 0)));
				end
			end
		end
		// instrument records
		first_ins_at = file_q.size();
		for (int i = 0; i < n_ins; i++) begin
			file_q.push_back(8'($urandom_range(255, 0)));
			file_q.push_back({5'($urandom_range(31, 0)), 3'($urandom_range(5, 0))});
			repeat (19) file_q.push_back(8'($urandom_range(255, 0)));
			cnt = ($urandom_range(31, 0) == 0) ? 255 : $urandom_range(3, 0);
			file_q.push_back(8'(cnt));
			repeat (cnt * (is_new ? 5 : 4)) file_q.push_back(8'($urandom_range(255, 0)));
		end
		// name table
		file_q[4] = 8'(file_q.size() >> 8);
		file_q[5] = 8'(file_q.size());
		for (int k = 0; k < n_names; k++) begin
			repeat ($urandom_range(5, 0)) file_q.push_back(8'($urandom_range(255, 1)));
			file_q.push_back(8'd0);
		end
		repeat (junk) file_q.push_back(8'($urandom_range(255, 1)));
	endtask

	task automatic cut_file(input int len);
		while (file_q.size() > len)
			void'(file_q.pop_back());
	endtask

	// Clean files of both formats, including the largest tables and counts
	task automatic test_valid_files();
		make_module(1'b1, 2, 4, 2, 1'b0, 1, 2, 3, 0);
		send_file();
		make_module(1'b0, 3, 4, 3, 1'b0, 2, 3, 4, 0);
		send_file();
		// track zero skipped and no tracks or instruments left
		make_module(1'b1, 1, 4, 1, 1'b1, 0, 0, 1, 0);
		send_file();
		make_module(1'b1, 1000, 16, 1, 1'b0, 0, 1, 2, 0);
		send_file();
		make_module(1'b0, 1, 4, 64, 1'b0, 0, 1, 2, 0);
		send_file();
		make_module(1'b1, 1, 4, 1, 1'b0, 0, 64, 65, 0);
		send_file();
	endtask

	// Bad magic and each header limit just outside; old-format version also at its maximum
	task automatic test_header_limits();
		make_module(1'b1, 1, 4, 1, 1'b0, 0, 1, 2, 0);
		file_q[2] = MAGIC_X;
		send_file();
		make_module(1'b1, 1, 4, 1, 1'b0, 0, 1, 2, 0);
		file_q[3] = NEW_VER_LIMIT;
		send_file();
		make_module(1'b0, 1, 4, 1, 1'b0, 0, 1, 2, 0);
		file_q[3] = OLD_VER_MAX;
		send_file();
		make_module(1'b0, 1, 4, 1, 1'b0, 0, 1, 2, 0);
		file_q[3] = OLD_VER_MAX + 8'd1;
		send_file();
		make_module(1'b0, 0, 4, 1, 1'b0, 0, 1, 2, 0);
		send_file();
		// position count one past the top
		make_module(1'b0, 1, 4, 1, 1'b0, 0, 1, 2, 0);
		file_q[6] = {file_q[6][7:4], 4'h3};
		file_q[7] = 8'hE9;
		send_file();
		make_module(1'b1, 1, 17, 1, 1'b0, 0, 1, 2, 0);
		send_file();
		make_module(1'b1, 1, 4, 0, 1'b0, 0, 1, 2, 0);
		send_file();
		make_module(1'b0, 1, 4, 65, 1'b0, 0, 1, 2, 0);
		send_file();
		make_module(1'b0, 1, 4, 1, 1'b0, 0, 65, 66, 0);
		send_file();
		make_module(1'b1, 1, 4, 1, 1'b0, 0, 1, 2, 0);
		file_q[15] = SUBSONG_FX_MAX + 8'd1;
		send_file();
	endtask

	// Short files, files cut in the header, tables, steps or instruments, and trailing bytes
	task automatic test_truncation();
		file_q.delete();
		file_q.push_back(8'($urandom_range(255, 0)));
		send_file();
		make_module(1'b1, 2, 4, 2, 1'b0, 1, 2, 3, 0);
		cut_file(15);
		send_file();
		make_module(1'b1, 2, 4, 2, 1'b0, 1, 2, 3, 0);
		cut_file(20);
		send_file();
		make_module(1'b0, 1, 4, 2, 1'b0, 1, 2, 3, 0);
		cut_file(first_step_at + 2);
		send_file();
		make_module(1'b1, 1, 4, 1, 1'b0, 0, 2, 3, 0);
		cut_file(first_ins_at + 10);
		send_file();
		// trailing bytes after a complete name table
		make_module(1'b0, 1, 4, 1, 1'b0, 0, 1, 2, 3);
		send_file();
	endtask

	// Instrument mode byte at and beyond its limit
	task automatic test_instrument_modes();
		make_module(1'b1, 1, 4, 1, 1'b0, 0, 2, 3, 0);
		file_q[first_ins_at + 1] = {5'd0, MODE_MAX + 3'd1};
		send_file();
		make_module(1'b0, 1, 4, 1, 1'b0, 0, 2, 3, 0);
		file_q[first_ins_at + 1] = 8'hFF;
		send_file();
		make_module(1'b0, 1, 4, 1, 1'b0, 0, 2, 3, 0);
		file_q[first_ins_at + 1] = {5'h1F, MODE_MAX};
		send_file();
	endtask

	// Name count short by one, rescued by a final NUL, and names inside the header
	task automatic test_name_table();
		make_module(1'b1, 1, 4, 1, 1'b0, 0, 2, 2, 1);
		send_file();
		make_module(1'b1, 1, 4, 1, 1'b0, 0, 2, 2, 0);
		send_file();
		make_module(1'b0, 1, 4, 1, 1'b0, 0, 0, 0, 1);
		send_file();
		make_module(1'b0, 1, 4, 1, 1'b0, 0, 1, 2, 0);
		file_q[4] = 8'd0;
		file_q[5] = 8'd0;
		send_file();
	endtask

	// Mostly well-formed files with random content, the rest cut, damaged or noise
	task automatic test_random_files(input int idle_pct, input int stall_pct, input int nfiles);
		bit is_new;
		int npos;
		int nch;
		int nsteps;
		int n_ins;
		int n_names;
		int sel;
		int idx;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (nfiles) begin
			is_new = 1'($urandom_range(1, 0));
			npos = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1);
			nch = !is_new ? 4 : ($urandom_range(7, 0) == 0) ? $urandom_range(16, 4) :
				$urandom_range(6, 4);
			nsteps = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 1) : $urandom_range(4, 1);
			n_ins = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 0) : $urandom_range(4, 0);
			n_names = ($urandom_range(4, 0) != 0) ? n_ins + 1 : $urandom_range(n_ins + 1, 0);
			make_module(is_new, npos, nch, nsteps, 1'($urandom_range(1, 0)),
				$urandom_range(2, 0), n_ins, n_names,
				($urandom_range(4, 0) == 0) ? $urandom_range(3, 1) : 0);
			sel = $urandom_range(99, 0);
			if (sel < 65) begin
			end else if (sel < 75) begin
				cut_file($urandom_range(file_q.size(), 1));
			end else if (sel < 85) begin
				repeat ($urandom_range(3, 1)) begin
					idx = $urandom_range(file_q.size() - 1, 0);
					file_q[idx] = 8'($urandom_range(255, 0));
				end
			end else if (sel < 92) begin
				file_q[$urandom_range(15, 0)] = 8'($urandom_range(255, 0));
			end else begin
				file_q.delete();
				repeat ($urandom_range(40, 1)) file_q.push_back(8'($urandom_range(255, 0)));
			end
			send_file();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_valid_files();
		test_header_limits();
		test_truncation();
		test_instrument_modes();
		test_name_table();
		test_random_files(0, 0, 16);
		test_random_files(83, 0, 16);
		test_random_files(0, 83, 16);
		test_random_files(26, 26, 16);
		s_tvalid <= 1'b0;
		// drain outstanding verdicts, then allow for pipeline latency
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("%0d files in %0d bytes: both formats, header limits, cut and damaged files,",
			files_seen, bytes_seen);
		$display("%0d verdicts checked (%0d valid) under four idle and stall mixes",
			verdicts_checked, verdicts_valid);
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: files.f
design/tmfv_pkg.sv
design/tracker_module_file_validator.sv
tb/sv/tb_tracker_module_file_validator.sv
